>>> sv/smx_pkg.sv
// shared types, opcodes and status codes of the stack machine execute unit
package smx_pkg;

  localparam int unsigned PC_W   = 13;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 5;
  localparam int unsigned ST_W   = 3;

  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned MEM_WORDS_DEF   = 256;
  localparam int unsigned PROGRAM_MAX_DEF = 4096;

  // opcodes
  localparam logic [OP_W-1:0] OP_LABEL = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 5'd1;
  localparam logic [OP_W-1:0] OP_LOADI = 5'd2;
  localparam logic [OP_W-1:0] OP_STO   = 5'd3;
  localparam logic [OP_W-1:0] OP_POP   = 5'd4;
  localparam logic [OP_W-1:0] OP_ADD   = 5'd5;
  localparam logic [OP_W-1:0] OP_SUB   = 5'd6;
  localparam logic [OP_W-1:0] OP_MULT  = 5'd7;
  localparam logic [OP_W-1:0] OP_DIV   = 5'd8;
  localparam logic [OP_W-1:0] OP_BR    = 5'd9;
  localparam logic [OP_W-1:0] OP_BRF   = 5'd10;
  localparam logic [OP_W-1:0] OP_EQ    = 5'd11;
  localparam logic [OP_W-1:0] OP_NOTEQ = 5'd12;
  localparam logic [OP_W-1:0] OP_GT    = 5'd13;
  localparam logic [OP_W-1:0] OP_LES   = 5'd14;
  localparam logic [OP_W-1:0] OP_GE    = 5'd15;
  localparam logic [OP_W-1:0] OP_LE    = 5'd16;
  localparam logic [OP_W-1:0] OP_AND   = 5'd17;
  localparam logic [OP_W-1:0] OP_OR    = 5'd18;
  localparam logic [OP_W-1:0] OP_NOT   = 5'd19;
  localparam logic [OP_W-1:0] OP_IN    = 5'd20;
  localparam logic [OP_W-1:0] OP_OUT   = 5'd21;
  localparam logic [OP_W-1:0] OP_STOP  = 5'd22;

  // status codes
  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_STOPPED = 3'd1;
  localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd2;
  localparam logic [ST_W-1:0] ST_UNDER   = 3'd3;
  localparam logic [ST_W-1:0] ST_OVER    = 3'd4;
  localparam logic [ST_W-1:0] ST_DIVZ    = 3'd5;
  localparam logic [ST_W-1:0] ST_ADDR    = 3'd6;

  typedef struct packed {
    logic [OP_W-1:0]          req_type;
    logic signed [DATA_W-1:0] operand;
    logic signed [DATA_W-1:0] in_value;
  } req_t;

  typedef struct packed {
    logic [PC_W-1:0]          next_pc;
    logic                     out_valid;
    logic signed [DATA_W-1:0] out_value;
    logic [ST_W-1:0]          status;
    logic                     running;
  } rsp_t;

  // classification done by the front end
  typedef struct packed {
    logic unknown;
    logic need_one;
    logic binop;
    logic push;
    logic addr_ok;
  } cls_t;

  typedef struct packed {
    req_t req;
    cls_t cls;
  } qent_t;

endpackage

>>> sv/smx_if.sv
// valid/ready channels for instruction words and result words
interface smx_req_if;
  logic          valid;
  logic          ready;
  smx_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface smx_rsp_if;
  logic          valid;
  logic          ready;
  smx_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/stack_machine_execute_unit.sv
// top level of the stack machine execute unit
//
//  channel  dir  handshake      word
//  req_i    in   valid/ready    req_type, operand, in_value
//  rsp_o    out  valid/ready    next_pc, out_valid, out_value, status, running
//  cfg      in   cfg_we_i       program_length (cfg_data_i)
//
// an instruction goes from queue to result register through pop, stack and
// memory read, and execute; the next pop waits until the result word is
// taken. divide adds a bit-serial quotient loop and a finishing step. the
// front queue holds two words so input keeps flowing while the back end
// works or its result waits. rst_ni clears stack pointer, pc, halt flag,
// memory valid bits and queue state at once; no clearing pass.
module stack_machine_execute_unit #(
  parameter int unsigned STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
  parameter int unsigned MEM_WORDS   = smx_pkg::MEM_WORDS_DEF,
  parameter int unsigned PROGRAM_MAX = smx_pkg::PROGRAM_MAX_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  smx_req_if.sink                  req_i,
  smx_rsp_if.source                rsp_o,
  input  logic                     cfg_we_i,
  input  logic [smx_pkg::PC_W-1:0] cfg_data_i
);

  // program length register
  logic [smx_pkg::PC_W-1:0] prog_len_q;

  // queue between classify and execute
  smx_pkg::qent_t q_data;
  logic           q_valid, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_len_q <= '0;
    end else if (cfg_we_i) begin
      prog_len_q <= cfg_data_i;
    end
  end

  smx_front #(.MEM_WORDS(MEM_WORDS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .q_data_o  (q_data),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop)
  );

  smx_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .MEM_WORDS   (MEM_WORDS),
    .PROGRAM_MAX (PROGRAM_MAX)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_data_i   (q_data),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .prog_len_i (prog_len_q),
    .rsp_o      (rsp_o)
  );

endmodule

>>> sv/smx_front.sv
// front end: accepts instruction words, classifies them, two-entry queue
module smx_front #(
  parameter int unsigned MEM_WORDS = smx_pkg::MEM_WORDS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  smx_req_if.sink        req_i,
  output smx_pkg::qent_t q_data_o,
  output logic           q_valid_o,
  input  logic           q_pop_i
);

  smx_pkg::cls_t  cls;
  smx_pkg::qent_t ent_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push_en, pop_en;
  logic [smx_pkg::OP_W-1:0] op;

  assign op = req_i.data.req_type;

  always_comb begin
    cls.unknown  = (op > smx_pkg::OP_STOP);
    cls.need_one = (op == smx_pkg::OP_POP) || (op == smx_pkg::OP_STO) ||
                   (op == smx_pkg::OP_BRF) || (op == smx_pkg::OP_NOT) ||
                   (op == smx_pkg::OP_OUT);
    cls.binop    = ((op >= smx_pkg::OP_ADD) && (op <= smx_pkg::OP_DIV)) ||
                   ((op >= smx_pkg::OP_EQ) && (op <= smx_pkg::OP_OR));
    cls.push     = (op == smx_pkg::OP_LOAD) || (op == smx_pkg::OP_LOADI) ||
                   (op == smx_pkg::OP_IN);
    cls.addr_ok  = !req_i.data.operand[31] &&
                   ($unsigned(req_i.data.operand) < 32'(MEM_WORDS));
  end

  assign req_i.ready = (cnt_q != 2'd2);
  assign push_en     = req_i.valid && req_i.ready;
  assign pop_en      = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o   = (cnt_q != 2'd0);
  assign q_data_o    = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      ent_q[wr_ptr_q] <= '{req: req_i.data, cls: cls};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_en) wr_ptr_q <= !wr_ptr_q;
      if (pop_en) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_en} - {1'b0, pop_en};
    end
  end

endmodule

>>> sv/smx_back.sv
// back end: stack, data memory, divider and result register
module smx_back #(
  parameter int unsigned STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
  parameter int unsigned MEM_WORDS   = smx_pkg::MEM_WORDS_DEF,
  parameter int unsigned PROGRAM_MAX = smx_pkg::PROGRAM_MAX_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  smx_pkg::qent_t           q_data_i,
  input  logic                     q_valid_i,
  output logic                     q_pop_o,
  input  logic [smx_pkg::PC_W-1:0] prog_len_i,
  smx_rsp_if.source                rsp_o
);

  localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IX_W = $clog2(STACK_DEPTH);
  localparam int unsigned MA_W = $clog2(MEM_WORDS);
  localparam int unsigned PC_W = smx_pkg::PC_W;
  localparam int unsigned DW   = smx_pkg::DATA_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EX   = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DFIN = 3'd4;

  logic [2:0]      state_q, state_d;
  smx_pkg::qent_t  cur_q;
  logic [SP_W-1:0] sp_q, sp_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic            halted_q, halted_d;
  smx_pkg::rsp_t   res_q, res_d;
  logic            res_vld_q, res_load;

  logic [DW-1:0]   stk [STACK_DEPTH];
  logic [DW-1:0]   dmem [MEM_WORDS];
  logic            dval_q [MEM_WORDS];
  logic [DW-1:0]   top_q, nxt_q, mrd_q;
  logic            mval_q;

  logic            stk_we;
  logic [IX_W-1:0] stk_wa;
  logic [DW-1:0]   stk_wd;
  logic            dm_we;
  logic [MA_W-1:0] dm_a;

  // divider
  logic [DW:0]     rem_q, rem_d;
  logic [DW-1:0]   quo_q, quo_d;
  logic [4:0]      dcnt_q, dcnt_d;
  logic [DW-1:0]   dvs_q, dvs_d;
  logic            dneg_q, dneg_d;
  logic [DW:0]     rem_sh;

  logic [PC_W-1:0] len;
  logic [DW-1:0]   opnd, a, b, r, prod;
  logic            tgt_ok;
  logic [smx_pkg::ST_W-1:0] st;
  logic [PC_W-1:0] npc;
  logic            outok;
  logic [DW-1:0]   outv;

  assign len  = ({{(DW-PC_W){1'b0}}, prog_len_i} > DW'(PROGRAM_MAX)) ?
                PC_W'(PROGRAM_MAX) : prog_len_i;
  assign opnd = cur_q.req.operand;
  assign a    = nxt_q;
  assign b    = top_q;
  assign prod = a * b;
  assign tgt_ok = !opnd[DW-1] && (opnd <= {{(DW-PC_W){1'b0}}, len});
  assign dm_a = opnd[MA_W-1:0];
  assign rem_sh = {rem_q[DW-1:0], quo_q[DW-1]};

  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i && !res_vld_q;
  assign rsp_o.valid = res_vld_q;
  assign rsp_o.data  = res_q;

  // stack and data memory, registered reads
  always_ff @(posedge clk_i) begin
    if (stk_we) stk[stk_wa] <= stk_wd;
    top_q <= stk[IX_W'(sp_q - SP_W'(1))];
    nxt_q <= stk[IX_W'(sp_q - SP_W'(2))];
    if (dm_we) dmem[dm_a] <= top_q;
    mrd_q  <= dmem[dm_a];
    mval_q <= dval_q[dm_a];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MEM_WORDS; i++) dval_q[i] <= 1'b0;
    end else if (dm_we) begin
      dval_q[dm_a] <= 1'b1;
    end
  end

  always_comb begin
    r = '0;
    unique case (cur_q.req.req_type)
      smx_pkg::OP_ADD:   r = a + b;
      smx_pkg::OP_SUB:   r = a - b;
      smx_pkg::OP_MULT:  r = prod;
      smx_pkg::OP_EQ:    r = DW'(a == b);
      smx_pkg::OP_NOTEQ: r = DW'(a != b);
      smx_pkg::OP_GT:    r = DW'($signed(a) > $signed(b));
      smx_pkg::OP_LES:   r = DW'($signed(a) < $signed(b));
      smx_pkg::OP_GE:    r = DW'($signed(a) >= $signed(b));
      smx_pkg::OP_LE:    r = DW'($signed(a) <= $signed(b));
      smx_pkg::OP_AND:   r = DW'((a != '0) && (b != '0));
      default:           r = DW'((a != '0) || (b != '0));
    endcase
  end

  always_comb begin
    state_d  = state_q;
    sp_d     = sp_q;
    pc_d     = pc_q;
    halted_d = halted_q;
    res_d    = res_q;
    res_load = 1'b0;
    stk_we   = 1'b0;
    stk_wa   = sp_q[IX_W-1:0];
    stk_wd   = '0;
    dm_we    = 1'b0;
    rem_d    = rem_q;
    quo_d    = quo_q;
    dcnt_d   = dcnt_q;
    dvs_d    = dvs_q;
    dneg_d   = dneg_q;
    st       = smx_pkg::ST_OK;
    npc      = pc_q + PC_W'(1);
    outok    = 1'b0;
    outv     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (q_pop_o) state_d = S_RD;
      end
      S_RD: state_d = S_EX;
      S_EX: begin
        state_d = S_IDLE;
        if (halted_q || pc_q >= len) begin
          res_d = '{next_pc: pc_q, out_valid: 1'b0, out_value: '0,
                    status: smx_pkg::ST_STOPPED, running: 1'b0};
          res_load = 1'b1;
        end else begin
          priority if (cur_q.cls.unknown) st = smx_pkg::ST_UNKNOWN;
          else if (cur_q.cls.binop && sp_q < SP_W'(2)) st = smx_pkg::ST_UNDER;
          else if (cur_q.cls.need_one && sp_q == '0) st = smx_pkg::ST_UNDER;
          else if (cur_q.cls.push && sp_q >= SP_W'(STACK_DEPTH)) st = smx_pkg::ST_OVER;
          else if ((cur_q.req.req_type == smx_pkg::OP_LOAD ||
                    cur_q.req.req_type == smx_pkg::OP_STO) && !cur_q.cls.addr_ok)
            st = smx_pkg::ST_ADDR;
          else if (cur_q.req.req_type == smx_pkg::OP_DIV && b == '0)
            st = smx_pkg::ST_DIVZ;
          else if (cur_q.req.req_type == smx_pkg::OP_BR && !tgt_ok)
            st = smx_pkg::ST_ADDR;
          else if (cur_q.req.req_type == smx_pkg::OP_BRF && top_q == '0 && !tgt_ok)
            st = smx_pkg::ST_ADDR;
          else st = smx_pkg::ST_OK;

          if (st == smx_pkg::ST_OK && cur_q.req.req_type == smx_pkg::OP_DIV) begin
            // start signed divide on magnitudes
            state_d = S_DIV;
            rem_d   = '0;
            quo_d   = a[DW-1] ? -a : a;
            dvs_d   = b[DW-1] ? -b : b;
            dneg_d  = a[DW-1] ^ b[DW-1];
            dcnt_d  = '0;
          end else begin
            if (st == smx_pkg::ST_OK) begin
              unique case (cur_q.req.req_type)
                smx_pkg::OP_LOAD: begin
                  stk_we = 1'b1;
                  stk_wd = mval_q ? mrd_q : '0;
                  sp_d   = sp_q + SP_W'(1);
                end
                smx_pkg::OP_LOADI: begin
                  stk_we = 1'b1;
                  stk_wd = opnd;
                  sp_d   = sp_q + SP_W'(1);
                end
                smx_pkg::OP_IN: begin
                  stk_we = 1'b1;
                  stk_wd = cur_q.req.in_value;
                  sp_d   = sp_q + SP_W'(1);
                end
                smx_pkg::OP_STO: dm_we = 1'b1;
                smx_pkg::OP_POP: sp_d = sp_q - SP_W'(1);
                smx_pkg::OP_BR: npc = opnd[PC_W-1:0];
                smx_pkg::OP_BRF: begin
                  if (top_q == '0) npc = opnd[PC_W-1:0];
                  sp_d = sp_q - SP_W'(1);
                end
                smx_pkg::OP_NOT: begin
                  stk_we = 1'b1;
                  stk_wa = IX_W'(sp_q - SP_W'(1));
                  stk_wd = DW'(top_q == '0);
                end
                smx_pkg::OP_OUT: begin
                  outok = 1'b1;
                  outv  = top_q;
                  sp_d  = sp_q - SP_W'(1);
                end
                smx_pkg::OP_STOP: begin
                  npc      = len;
                  halted_d = 1'b1;
                  st       = smx_pkg::ST_STOPPED;
                end
                default: begin
                  if (cur_q.cls.binop) begin
                    stk_we = 1'b1;
                    stk_wa = IX_W'(sp_q - SP_W'(2));
                    stk_wd = r;
                    sp_d   = sp_q - SP_W'(1);
                  end
                end
              endcase
            end else begin
              halted_d = 1'b1;
              npc      = pc_q;
            end
            pc_d = npc;
            res_d = '{next_pc: npc, out_valid: outok, out_value: outv, status: st,
                      running: !halted_d && (npc < len)};
            res_load = 1'b1;
          end
        end
      end
      S_DIV: begin
        // one quotient bit per cycle, restoring
        if (rem_sh >= {1'b0, dvs_q}) begin
          rem_d = rem_sh - {1'b0, dvs_q};
          quo_d = {quo_q[DW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[DW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd31) state_d = S_DFIN;
      end
      S_DFIN: begin
        state_d = S_IDLE;
        stk_we  = 1'b1;
        stk_wa  = IX_W'(sp_q - SP_W'(2));
        stk_wd  = dneg_q ? -quo_q : quo_q;
        sp_d    = sp_q - SP_W'(1);
        pc_d    = npc;
        res_d   = '{next_pc: npc, out_valid: 1'b0, out_value: '0,
                    status: smx_pkg::ST_OK, running: npc < len};
        res_load = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_data_i;
    if (res_load) res_q <= res_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    dneg_q <= dneg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sp_q      <= '0;
      pc_q      <= '0;
      halted_q  <= 1'b0;
      res_vld_q <= 1'b0;
      dcnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      sp_q     <= sp_d;
      pc_q     <= pc_d;
      halted_q <= halted_d;
      dcnt_q   <= dcnt_d;
      if (res_load) res_vld_q <= 1'b1;
      else if (rsp_o.ready) res_vld_q <= 1'b0;
    end
  end

endmodule

>>> sv/smx_checker.sv
// port-level checks of the execute unit and their binding
module smx_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic                      rsp_out_valid_i,
  input logic                      rsp_running_i,
  input logic [smx_pkg::ST_W-1:0]  rsp_status_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result word dropped while stalled");

  a_run_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_running_i |-> rsp_status_i == smx_pkg::ST_OK)
    else $error("running with non-ok status");

  a_out_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_out_valid_i |-> rsp_status_i == smx_pkg::ST_OK)
    else $error("output value with non-ok status");

  a_err_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != smx_pkg::ST_OK |-> !rsp_running_i && !rsp_out_valid_i)
    else $error("error or stop without halt");

endmodule

bind stack_machine_execute_unit smx_checker u_smx_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_out_valid_i (rsp_o.data.out_valid),
  .rsp_running_i   (rsp_o.data.running),
  .rsp_status_i    (rsp_o.data.status)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the stack machine execute unit
module tb_top;
  import smx_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [PC_W-1:0] cfg_data_i;

  smx_req_if req_ch();
  smx_rsp_if rsp_ch();

  stack_machine_execute_unit dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_ch.sink),
    .rsp_o     (rsp_ch.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i)
  );

  // machine copy used to work out each result word
  logic [DATA_W-1:0] mdl_stack [STACK_DEPTH_DEF];
  logic [DATA_W-1:0] mdl_mem [MEM_WORDS_DEF];
  int unsigned mdl_sp;
  int unsigned mdl_pc;
  bit mdl_halted;
  int unsigned mdl_plen;

  req_t instr_q[$];   // instruction words waiting to be offered
  rsp_t result_q[$];  // result words still owed by the block

  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  bit long_hold_req;
  int unsigned hold_cnt;
  bit req_fire;
  bit failed;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // program length as the block sees it: capped at PROGRAM_MAX_DEF for large register values
  function automatic int unsigned eff_len();
    return (mdl_plen > PROGRAM_MAX_DEF) ? PROGRAM_MAX_DEF : mdl_plen;
  endfunction

  // one instruction on the machine copy; returns the result word
  function automatic rsp_t exec_word(req_t w);
    rsp_t rs;
    logic [DATA_W-1:0] a, b, r;
    longint s, sa, sb;
    int unsigned need, len, npc;
    bit push, binop;
    logic [OP_W-1:0] op;
    logic [ST_W-1:0] st;
    op = w.req_type;
    s = longint'(w.operand);
    len = eff_len();
    rs = '0;
    // halted or past the end: nothing moves
    if (mdl_halted || mdl_pc >= len) begin
      rs.next_pc = mdl_pc[PC_W-1:0];
      rs.status = ST_STOPPED;
      return rs;
    end
    npc = mdl_pc + 1;
    need = 0;
    push = 0;
    binop = 0;
    a = '0;
    b = '0;
    r = '0;
    st = ST_OK;
    if (op == OP_POP || op == OP_STO || op == OP_BRF || op == OP_NOT || op == OP_OUT) begin
      need = 1;
    end else if ((op >= OP_ADD && op <= OP_DIV) || (op >= OP_EQ && op <= OP_OR)) begin
      need = 2;
      binop = 1;
    end else if (op == OP_LOAD || op == OP_LOADI || op == OP_IN) begin
      push = 1;
    end
    // error priority: opcode, underflow, overflow, memory address
    if (op > OP_STOP) st = ST_UNKNOWN;
    else if (mdl_sp < need) st = ST_UNDER;
    else if (push && mdl_sp >= STACK_DEPTH_DEF) st = ST_OVER;
    else if ((op == OP_LOAD || op == OP_STO) && (s < 0 || s >= MEM_WORDS_DEF)) st = ST_ADDR;
    if (st == ST_OK && binop) begin
      b = mdl_stack[mdl_sp-1];
      a = mdl_stack[mdl_sp-2];
      if (op == OP_DIV && b == 0) st = ST_DIVZ;
    end
    if (st == ST_OK) begin
      sa = longint'($signed(a));
      sb = longint'($signed(b));
      case (op)
        OP_LABEL: ;
        OP_LOAD: begin
          mdl_stack[mdl_sp] = mdl_mem[s];
          mdl_sp++;
        end
        OP_LOADI, OP_IN: begin
          mdl_stack[mdl_sp] = (op == OP_IN) ? w.in_value : w.operand;
          mdl_sp++;
        end
        OP_STO: mdl_mem[s] = mdl_stack[mdl_sp-1];
        OP_POP: mdl_sp--;
        OP_BR: begin
          if (s < 0 || s > len) st = ST_ADDR;
          else npc = s;
        end
        OP_BRF: begin
          // pops unless the jump target is bad, jumps only on zero
          if (mdl_stack[mdl_sp-1] == 0 && (s < 0 || s > len)) st = ST_ADDR;
          else begin
            if (mdl_stack[mdl_sp-1] == 0) npc = s;
            mdl_sp--;
          end
        end
        OP_NOT: mdl_stack[mdl_sp-1] = (mdl_stack[mdl_sp-1] == 0) ? 1 : 0;
        OP_OUT: begin
          mdl_sp--;
          rs.out_value = mdl_stack[mdl_sp];
          rs.out_valid = 1'b1;
        end
        OP_STOP: begin
          npc = len;
          mdl_halted = 1;
          st = ST_STOPPED;
        end
        default: begin
          case (op)
            OP_ADD:   r = a + b;
            OP_SUB:   r = a - b;
            OP_MULT:  r = a * b;
            // 64-bit divide: most negative / -1 wraps, truncates toward zero
            OP_DIV:   r = 32'(sa / sb);
            OP_EQ:    r = (sa == sb);
            OP_NOTEQ: r = (sa != sb);
            OP_GT:    r = (sa > sb);
            OP_LES:   r = (sa < sb);
            OP_GE:    r = (sa >= sb);
            OP_LE:    r = (sa <= sb);
            OP_AND:   r = (a != 0 && b != 0);
            default:  r = (a != 0 || b != 0);
          endcase
          mdl_sp--;
          mdl_stack[mdl_sp-1] = r;
        end
      endcase
    end
    // errors halt and keep pc where it was
    if (st != ST_OK && st != ST_STOPPED) begin
      mdl_halted = 1;
      npc = mdl_pc;
      rs.out_valid = 1'b0;
      rs.out_value = '0;
    end
    mdl_pc = npc;
    rs.next_pc = npc[PC_W-1:0];
    rs.status = st;
    rs.running = (!mdl_halted && npc < len);
    return rs;
  endfunction

  // queue one instruction word along with its predicted result
  task automatic issue(logic [OP_W-1:0] op, logic [DATA_W-1:0] opnd, logic [DATA_W-1:0] inv);
    req_t w;
    w.req_type = op;
    w.operand = opnd;
    w.in_value = inv;
    instr_q = {instr_q, w};
    result_q = {result_q, exec_word(w)};
  endtask

  // extremes, small values and plain random words
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 20) begin
      case ($urandom_range(0, 4))
        0: return 32'h0;
        1: return 32'h1;
        2: return 32'hFFFF_FFFF;
        3: return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    if (k < 45) return 32'($signed($urandom_range(0, 8)) - 4);
    return $urandom();
  endfunction

  // branch back before the program would run off its end
  task automatic keep_in_program();
    if (mdl_pc + 1 >= eff_len())
      issue(OP_BR, $urandom_range(0, eff_len() - 2), $urandom());
  endtask

  function automatic bit op_is_legal(logic [OP_W-1:0] op);
    if (op == OP_POP || op == OP_STO || op == OP_BRF || op == OP_NOT || op == OP_OUT)
      return mdl_sp >= 1;
    if ((op >= OP_ADD && op <= OP_DIV) || (op >= OP_EQ && op <= OP_OR)) begin
      if (mdl_sp < 2) return 0;
      return !(op == OP_DIV && mdl_stack[mdl_sp-1] == 0);
    end
    if (op == OP_LOAD || op == OP_LOADI || op == OP_IN)
      return mdl_sp < STACK_DEPTH_DEF;
    return op != OP_STOP;
  endfunction

  // well-formed random program: no error, no stop, stays inside the program
  task automatic gen_program(int unsigned n);
    logic [OP_W-1:0] op;
    logic [DATA_W-1:0] opnd;
    repeat (n) begin
      keep_in_program();
      do begin
        // lean toward pushes when the stack is shallow
        if (mdl_sp < 3 && $urandom_range(0, 1)) op = $urandom_range(0, 1) ? OP_IN : OP_LOADI;
        else op = OP_W'($urandom_range(0, OP_STOP - 1));
      end while (!op_is_legal(op));
      if (op == OP_LOAD || op == OP_STO) opnd = $urandom_range(0, MEM_WORDS_DEF - 1);
      else if (op == OP_BR || op == OP_BRF) opnd = $urandom_range(0, eff_len() - 2);
      else opnd = pick_value();
      issue(op, opnd, pick_value());
    end
  endtask

  // the one event that halts the machine for the rest of the run
  task automatic gen_halt();
    case ($urandom_range(0, 6))
      0: issue(OP_STOP, $urandom(), $urandom());
      1: issue(OP_W'($urandom_range(OP_STOP + 1, 31)), $urandom(), $urandom());
      2: begin
        while (mdl_sp > 0) begin
          keep_in_program();
          issue(OP_POP, $urandom(), $urandom());
        end
        issue(OP_W'(OP_ADD + $urandom_range(0, 3)), $urandom(), $urandom());
      end
      3: begin
        while (mdl_sp < STACK_DEPTH_DEF) begin
          keep_in_program();
          issue(OP_IN, $urandom(), $urandom());
        end
        issue(OP_LOADI, $urandom(), $urandom());
      end
      4: begin
        keep_in_program();
        issue(OP_LOADI, pick_value(), $urandom());
        keep_in_program();
        issue(OP_LOADI, 32'h0, $urandom());
        keep_in_program();
        issue(OP_DIV, $urandom(), $urandom());
      end
      5: issue($urandom_range(0, 1) ? OP_LOAD : OP_STO,
               $urandom_range(0, 1) ? 32'($urandom_range(MEM_WORDS_DEF, 32'h7FFF_FFFF))
                                    : 32'h8000_0000 | $urandom(), $urandom());
      default: issue(OP_BR, $urandom_range(0, 1) ? eff_len() + 1 : 32'hFFFF_FFFF, $urandom());
    endcase
    // once halted every word just reports stopped
    repeat (4) issue(OP_W'($urandom_range(0, 31)), $urandom(), $urandom());
  endtask

  task automatic wait_drain();
    while (instr_q.size() != 0 || result_q.size() != 0 || req_ch.valid) @(posedge clk_i);
    // let a divide still in flight show up before touching the register
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_length(int unsigned v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v[PC_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mdl_plen = v;
  endtask

  // ---------------------------------------------------------------------
  // instruction driver: presents the next queued word once the previous
  // one was taken; random idle gaps between words
  // ---------------------------------------------------------------------
  always @(posedge clk_i) req_fire <= req_ch.valid && req_ch.ready;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fire) begin
      if (instr_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        req_ch.data <= instr_q.pop_front();
        req_ch.valid <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // result side: random ready, plus one long hold-off on request so the
  // front queue fills and back-pressures the instruction channel
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      hold_cnt <= 0;
    end else if (long_hold_req && hold_cnt == 0) begin
      long_hold_req = 1'b0;
      hold_cnt <= 120;
      rsp_ch.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      rsp_ch.ready <= (hold_cnt == 1);
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // compare each taken result word with the oldest prediction
  always @(posedge clk_i) begin
    rsp_t want;
    rsp_t got;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (result_q.size() == 0) begin
        $display("%0t unexpected result word %h", $time, got);
        failed = 1'b1;
      end else begin
        want = result_q.pop_front();
        if (got.next_pc !== want.next_pc) begin
          $display("%0t next_pc exp %0d got %0d", $time, want.next_pc, got.next_pc);
          failed = 1'b1;
        end
        if (got.out_valid !== want.out_valid) begin
          $display("%0t out_valid exp %b got %b", $time, want.out_valid, got.out_valid);
          failed = 1'b1;
        end
        if (got.out_value !== want.out_value) begin
          $display("%0t out_value exp %h got %h", $time, want.out_value, got.out_value);
          failed = 1'b1;
        end
        if (got.status !== want.status) begin
          $display("%0t status exp %0d got %0d", $time, want.status, got.status);
          failed = 1'b1;
        end
        if (got.running !== want.running) begin
          $display("%0t running exp %b got %b", $time, want.running, got.running);
          failed = 1'b1;
        end
      end
    end
  end

  // run limit, far above the slowest legal run
  initial begin
    #4ms;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // phase sequencer
  // ---------------------------------------------------------------------
  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    failed = 1'b0;
    long_hold_req = 1'b0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    mdl_sp = 0;
    mdl_pc = 0;
    mdl_halted = 0;
    mdl_plen = 0;
    foreach (mdl_stack[i]) mdl_stack[i] = '0;
    foreach (mdl_mem[i]) mdl_mem[i] = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // program length zero after reset: past the end at once
    issue(OP_LOADI, 32'h1234, 32'h0);
    issue(OP_LABEL, 32'h0, 32'h0);
    wait_drain();

    // directed program on a short length
    write_length(40);
    issue(OP_LABEL, 32'h0, 32'h0);
    issue(OP_LOAD, 32'd255, 32'h0);          // memory never written reads zero
    issue(OP_LOADI, 32'h8000_0000, 32'h0);
    issue(OP_LOADI, 32'hFFFF_FFFF, 32'h0);
    issue(OP_DIV, 32'h0, 32'h0);             // most negative / -1 wraps
    issue(OP_LOADI, 32'h7FFF_FFFF, 32'h0);
    issue(OP_MULT, 32'h0, 32'h0);
    issue(OP_STO, 32'd0, 32'h0);             // keeps the top
    issue(OP_LOAD, 32'd0, 32'h0);
    issue(OP_SUB, 32'h0, 32'h0);
    issue(OP_LOADI, 32'hFFFF_FFF9, 32'h0);
    issue(OP_LOADI, 32'd2, 32'h0);
    issue(OP_DIV, 32'h0, 32'h0);             // truncates toward zero
    issue(OP_LES, 32'h0, 32'h0);
    issue(OP_IN, 32'h0, 32'h7FFF_FFFF);
    issue(OP_GE, 32'h0, 32'h0);
    issue(OP_IN, 32'h0, 32'h8000_0000);
    issue(OP_GT, 32'h0, 32'h0);
    issue(OP_IN, 32'h0, 32'hFFFF_FFFB);
    issue(OP_LE, 32'h0, 32'h0);
    issue(OP_NOT, 32'h0, 32'h0);
    issue(OP_LOADI, 32'h0, 32'h0);
    issue(OP_EQ, 32'h0, 32'h0);
    issue(OP_IN, 32'h0, 32'h0);
    issue(OP_NOTEQ, 32'h0, 32'h0);
    issue(OP_LOADI, 32'h7FFF_FFFF, 32'h0);
    issue(OP_AND, 32'h0, 32'h0);
    issue(OP_LOADI, 32'h0, 32'h0);
    issue(OP_OR, 32'h0, 32'h0);
    issue(OP_OUT, 32'h0, 32'h0);
    issue(OP_LOADI, 32'h0, 32'h0);
    issue(OP_BRF, 32'd33, 32'h0);            // zero on top: jumps
    issue(OP_LOADI, 32'd5, 32'h0);
    issue(OP_BRF, 32'd0, 32'h0);             // nonzero: falls through
    issue(OP_POP, 32'h0, 32'h0);             // leaves the stack empty, machine still runs
    wait_drain();

    snd_idle_pct = 21;
    rcv_idle_pct = 78;
    write_length(8191);                      // above the maximum, acts as the maximum
    gen_program(230);
    wait_drain();

    // run to the end of a short program, then lengthen it again
    snd_idle_pct = 78;
    rcv_idle_pct = 21;
    write_length(60);
    issue(OP_BR, 32'd60, 32'h0);
    issue(OP_LOADI, 32'h1, 32'h0);
    wait_drain();
    write_length(0);
    issue(OP_LABEL, 32'h0, 32'h0);
    wait_drain();
    write_length(4096);
    gen_program(230);
    wait_drain();

    // no idling; the result side holds off for a long stretch first
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    long_hold_req = 1'b1;
    gen_program(230);
    gen_halt();
    wait_drain();

    if (failed) begin
      $display("status: fail");
    end else begin
      $display("status: pass");
    end
    $finish;
  end

endmodule

>>> files.f
sv/smx_pkg.sv
sv/smx_if.sv
sv/smx_front.sv
sv/smx_back.sv
sv/stack_machine_execute_unit.sv
sv/smx_checker.sv
tb/sv/tb_top.sv
